/* design/oaht_pkg.sv */
`default_nettype none
package oaht_pkg;

  localparam int TABLE_SLOTS_DEF = 26;
  localparam int KEY_CHARS_DEF   = 29;
  localparam int NUM_LETTERS     = 26;
  localparam int RAW_KEY_W       = 232;
  localparam int OUT_SLOT_W      = 5;
  localparam int OUT_PROBES_W    = 5;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CH_CASE_OFS = 8'd32;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic PROBE_LINEAR    = 1'b0;
  localparam logic PROBE_QUADRATIC = 1'b1;

  // register index is paddr[2]
  localparam logic REG_PROBE_MODE = 1'b0;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_NO_FREE   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_KEY   = 3'd4
  } status_t;

  typedef struct packed {
    logic        func;
    logic [63:0] key_chars_0_7;
    logic [63:0] key_chars_8_15;
    logic [63:0] key_chars_16_23;
    logic [39:0] key_chars_24_28;
  } in_req_t;

  typedef struct packed {
    status_t                   status;
    logic [OUT_SLOT_W-1:0]     slot;
    logic [OUT_PROBES_W-1:0]   probes;
  } out_rsp_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      r = c + CH_CASE_OFS;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/oaht_ram.sv */
`default_nettype none
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/oaht_keyprep.sv */
`default_nettype none
module oaht_keyprep
  import oaht_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int KEY_CHARS   = KEY_CHARS_DEF,
  localparam int KEY_W = 8 * KEY_CHARS,
  localparam int IDX_W = $clog2(TABLE_SLOTS)
) (
  input  wire logic [KEY_W-1:0] raw_key,
  output logic      [KEY_W-1:0] norm_key,
  output logic      [IDX_W-1:0] home,
  output logic                  bad
);

  logic [IDX_W-1:0] home_tbl [32];
  logic [7:0]       c0;
  logic [4:0]       letter;

  // home slot of each letter index, worked out at elaboration
  for (genvar g = 0; g < 32; g++) begin : g_home
    localparam int HV = (g < NUM_LETTERS) ? (g % TABLE_SLOTS) : 0;
    assign home_tbl[g] = IDX_W'(HV);
  end

  // zero everything after the first NUL, fold case on the rest
  always_comb begin
    logic ended;
    logic [7:0] c;
    ended = 1'b0;
    norm_key = '0;
    for (int n = 0; n < KEY_CHARS; n++) begin
      c = raw_key[8*n +: 8];
      if (c == 8'd0) begin
        ended = 1'b1;
      end
      norm_key[8*n +: 8] = ended ? 8'd0 : fold_char(c);
    end
  end

  assign c0     = norm_key[7:0];
  assign bad    = !(c0 inside {[CH_LOWER_A:CH_LOWER_Z]});
  assign letter = 5'(c0 - CH_LOWER_A);
  assign home   = home_tbl[letter];

endmodule
`default_nettype wire

/* design/oaht_probe.sv */
`default_nettype none
module oaht_probe
  import oaht_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  localparam int IDX_W = $clog2(TABLE_SLOTS)
) (
  input  wire logic             mode,
  input  wire logic [IDX_W-1:0] off,
  input  wire logic [IDX_W-1:0] inc,
  input  wire logic [IDX_W-1:0] idx,
  output logic      [IDX_W-1:0] off_nxt,
  output logic      [IDX_W-1:0] inc_nxt,
  output logic      [IDX_W-1:0] idx_nxt
);

  localparam int TWO_MOD = 2 % TABLE_SLOTS;

  // both operands below TABLE_SLOTS, so one subtract reduces the sum
  function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(TABLE_SLOTS)) begin
      s = s - (IDX_W+1)'(TABLE_SLOTS);
    end
    return s[IDX_W-1:0];
  endfunction

  // quadratic: j*j grows by 2j+1, which itself grows by 2
  assign off_nxt = mod_add(off, inc);
  assign idx_nxt = mod_add(idx, inc);
  assign inc_nxt = (mode == PROBE_QUADRATIC) ? mod_add(inc, IDX_W'(TWO_MOD)) : inc;

endmodule
`default_nettype wire

/* design/open_addressing_hash_table_unit.sv */
`default_nettype none
// Request path: S_IDLE registers the key, S_PREP normalises it and finishes a bad key; insert
// probes in S_INS and lookup in S_LOOK, and a blocked result holds the finishing state; one slot
// is probed per cycle, set by the single key RAM read port and the shared probe adder.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset (rst_n low, synchronous): table empty, probe_mode linear, no result pending.
// No clearing pass: the slot-used flags are flip-flops cleared by reset.
module open_addressing_hash_table_unit
  import oaht_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int KEY_CHARS   = KEY_CHARS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_req_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_rsp_t                   out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int KEY_W = 8 * KEY_CHARS;
  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_INS, S_LOOK} state_t;

  state_t                 state_r, state_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic                   func_r, func_nxt;
  logic [IDX_W-1:0]       off_r, off_nxt;
  logic [IDX_W-1:0]       inc_r, inc_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       j_r, j_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]       pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0]       pend_j_r, pend_j_nxt;
  logic [TABLE_SLOTS-1:0] used_r, used_nxt;
  logic                   mode_r, mode_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_rsp_t               out_r, out_nxt;

  logic [RAW_KEY_W-1:0] raw_key;
  logic [KEY_W-1:0]     prep_key;
  logic [IDX_W-1:0]     prep_home;
  logic                 prep_bad;
  logic [IDX_W-1:0]     pu_off, pu_inc, pu_idx;
  logic                 ram_we, ram_re;
  logic [KEY_W-1:0]     ram_rdata;
  logic                 out_free;
  logic                 finish;
  out_rsp_t             fin_rsp;
  logic                 cfg_wr;

  assign raw_key = {in_data.key_chars_24_28, in_data.key_chars_16_23,
                    in_data.key_chars_8_15, in_data.key_chars_0_7};

  oaht_keyprep #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .KEY_CHARS  (KEY_CHARS)
  ) u_keyprep (
    .raw_key (key_r),
    .norm_key(prep_key),
    .home    (prep_home),
    .bad     (prep_bad)
  );

  oaht_probe #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_probe (
    .mode   (mode_r),
    .off    (off_r),
    .inc    (inc_r),
    .idx    (idx_r),
    .off_nxt(pu_off),
    .inc_nxt(pu_inc),
    .idx_nxt(pu_idx)
  );

  oaht_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_key_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx_r),
    .wdata(key_r),
    .re   (ram_re),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign prdata    = (paddr[CFG_ADDR_W-1] == REG_PROBE_MODE) ?
                     CFG_DATA_W'(mode_r) : '0;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    func_nxt      = func_r;
    off_nxt       = off_r;
    inc_nxt       = inc_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    pend_v_nxt    = pend_v_r;
    pend_idx_nxt  = pend_idx_r;
    pend_j_nxt    = pend_j_r;
    used_nxt      = used_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    finish        = 1'b0;
    fin_rsp       = '{status: ST_NOT_FOUND, slot: '0, probes: '0};

    if (cfg_wr && (paddr[CFG_ADDR_W-1] == REG_PROBE_MODE)) begin
      mode_nxt = pwdata[0];
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt   = raw_key[KEY_W-1:0];
          func_nxt  = in_data.func;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (prep_bad) begin
          finish  = 1'b1;
          fin_rsp = '{status: ST_BAD_KEY, slot: '0, probes: '0};
        end else begin
          key_nxt    = prep_key;
          idx_nxt    = prep_home;
          off_nxt    = '0;
          inc_nxt    = IDX_W'(1);
          j_nxt      = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = (func_r == FUNC_LOOKUP) ? S_LOOK : S_INS;
        end
      end
      S_INS: begin
        if ((j_r != '0) && (off_r == '0)) begin
          finish  = 1'b1;
          fin_rsp = '{status: ST_NO_FREE, slot: '0, probes: '0};
        end else if (!used_r[idx_r]) begin
          finish  = 1'b1;
          fin_rsp = '{status: ST_INSERTED, slot: OUT_SLOT_W'(idx_r), probes: '0};
          if (out_free) begin
            ram_we           = 1'b1;
            used_nxt[idx_r]  = 1'b1;
          end
        end else begin
          off_nxt = pu_off;
          inc_nxt = pu_inc;
          idx_nxt = pu_idx;
          j_nxt   = j_r + CNT_W'(1);
        end
      end
      S_LOOK: begin
        // the read issued last cycle is older and wins over the current probe
        if (pend_v_r && (ram_rdata == key_r)) begin
          finish  = 1'b1;
          fin_rsp = '{status: ST_FOUND, slot: OUT_SLOT_W'(pend_idx_r),
                      probes: OUT_PROBES_W'(pend_j_r)};
        end else if ((j_r != '0) && (off_r == '0)) begin
          finish  = 1'b1;
          fin_rsp = '{status: ST_NOT_FOUND, slot: '0,
                      probes: OUT_PROBES_W'(j_r - CNT_W'(1))};
        end else if ((j_r != '0) && !used_r[idx_r]) begin
          finish  = 1'b1;
          fin_rsp = '{status: ST_NOT_FOUND, slot: '0, probes: OUT_PROBES_W'(j_r)};
        end else begin
          ram_re       = used_r[idx_r];
          pend_v_nxt   = used_r[idx_r];
          pend_idx_nxt = idx_r;
          pend_j_nxt   = j_r;
          off_nxt      = pu_off;
          inc_nxt      = pu_inc;
          idx_nxt      = pu_idx;
          j_nxt        = j_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // hold the finishing cycle until the result register frees up
    if (finish && out_free) begin
      out_valid_nxt = 1'b1;
      out_nxt       = fin_rsp;
      pend_v_nxt    = 1'b0;
      state_nxt     = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      j_r         <= '0;
      pend_v_r    <= 1'b0;
      used_r      <= '0;
      mode_r      <= PROBE_LINEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      pend_v_r    <= pend_v_nxt;
      used_r      <= used_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r      <= key_nxt;
    func_r     <= func_nxt;
    off_r      <= off_nxt;
    inc_r      <= inc_nxt;
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_j_r   <= pend_j_nxt;
    out_r      <= out_nxt;
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_INS) && !used_r[idx_r])
    else $error("insert writes a slot that is already used");

  a_pend_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (state_r == S_LOOK))
    else $error("pending key read outside lookup");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_INS) || (state_r == S_LOOK)) |->
      (idx_r < IDX_W'(TABLE_SLOTS - 1)) || (idx_r == IDX_W'(TABLE_SLOTS - 1)))
    else $error("probe index beyond table");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && !out_free) |=> (state_r == $past(state_r)) && (j_r == $past(j_r)))
    else $error("sequencer advanced while result was blocked");
`endif

endmodule
`default_nettype wire
